FILE: hdl/i2cm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Configuration register indexes and reset values.
    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 16;
    localparam logic [CfgIndexW-1:0] CFG_HALF_PERIOD   = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_STRETCH_LIMIT = 2'd1;
    localparam logic [8:0]  HalfPeriodReset   = 9'd5;
    localparam logic [15:0] StretchLimitReset = 16'd10000;

    // Input kind codes as they appear on the bus.
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    localparam logic [3:0] BitsPerByte = 4'd8;

    // Depth of the queue between front and back.
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // Stream widths.
    localparam int InDataW  = 16;
    localparam int InUserW  = 3;
    localparam int OutDataW = 16;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_S0,
        PH_S1,
        PH_S2,
        PH_P0,
        PH_P1,
        PH_P2,
        PH_W0,
        PH_W1,
        PH_W2,
        PH_WA0,
        PH_WA1,
        PH_WA2,
        PH_R0,
        PH_R1,
        PH_RA0,
        PH_RA1,
        PH_RA2
    } phase_t;

    // One classified tick as it travels through the queue.
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } item_t;

    // Queue read side as seen by the back end.
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

endpackage : i2cm_pkg
`default_nettype wire

FILE: hdl/i2c_master_byte_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain I2C master byte engine driven by one tick beat per cycle while not back-pressured.
// ----------------------------------------------------------------------------
// Throughput: one tick beat in and one result beat out per cycle while the
//   output side takes each result beat; m_tready low holds the back end.
// Path: an accepted input beat is first written into the queue, then the
//   engine step registers its result in the output register; a stall on the
//   output side holds the item in the queue.
// Reset: rst_n clears all control state at once and loads half_period = 5
//   and stretch_limit = 10000; no clearing pass is needed.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port.
    input  wire logic                 cfg_we,
    input  wire logic [CfgIndexW-1:0] cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_data,
    // Tick beats in.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [InDataW-1:0]   s_tdata,  // tx_byte[7:0], send_ack, scl_in, sda_in, 0s
    input  wire logic [InUserW-1:0]   s_tuser,  // kind
    // Result beats out.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OutDataW-1:0]       m_tdata   // scl_drive_low, sda_drive_low, ready_res,
                                                // done_res, rx_byte[7:0], ack_seen,
                                                // stretch_timeout, 0s
);

    // The front end turns each beat into a classified item and pushes it into
    // the queue whenever there is room, so the input side keeps moving while
    // a finished result waits on the output side, until the queue is full.
    logic    q_full;
    logic    q_push;
    logic    q_pop;
    item_t   q_item;
    q_head_t q_head;

    i2cm_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    i2cm_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .item_in (q_item),
        .pop     (q_pop),
        .head    (q_head),
        .full    (q_full)
    );

    // The back end runs the segment sequencer for one tick per popped item and
    // holds the result in an output register until the beat is taken.
    i2cm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (q_head),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A command can only finish while the engine is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done reported on an idle tick");

    // A new result only appears after the queue offered an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(q_head.valid))
        else $error("result beat without a queued item");

    // The queue is never written while it reports full.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push into a full queue");

endmodule : i2c_master_byte_engine
`default_nettype wire

FILE: hdl/i2cm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input beats and classifies the kind code into a command.
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [InDataW-1:0] s_tdata,   // tx_byte, send_ack, scl_in, sda_in
    input  wire logic [InUserW-1:0] s_tuser,   // kind
    input  wire logic               q_full,
    output logic                    q_push,
    output item_t                   q_item
);

    cmd_t cmd;

    // Unknown kinds become no command, so the back end starts no command on them.
    always_comb
    begin
        case (s_tuser)
            KIND_START: cmd = CMD_START;
            KIND_STOP:  cmd = CMD_STOP;
            KIND_WRITE: cmd = CMD_WRITE;
            KIND_READ:  cmd = CMD_READ;
            default:    cmd = CMD_NONE;
        endcase
    end

    assign s_tready         = !q_full;
    assign q_push           = s_tvalid && !q_full;
    assign q_item.cmd       = cmd;
    assign q_item.tx_byte   = s_tdata[7:0];
    assign q_item.send_ack  = s_tdata[8];
    assign q_item.scl_in    = s_tdata[9];
    assign q_item.sda_in    = s_tdata[10];

endmodule : i2cm_front
`default_nettype wire

FILE: hdl/i2cm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_queue
// Short flop-based FIFO that decouples the front and back ends.
// ----------------------------------------------------------------------------
module i2cm_queue
    import i2cm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire item_t  item_in,
    input  wire logic   pop,
    output q_head_t     head,
    output logic        full
);

    item_t                mem_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0] count_reg, count_next;
    logic                 do_pop;

    assign full      = (count_reg == QueueCntW'(QueueDepth));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule : i2cm_queue
`default_nettype wire

FILE: hdl/i2cm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_back
// Bus engine: runs one tick per queued item and registers one result beat.
// ----------------------------------------------------------------------------
module i2cm_back
    import i2cm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CfgIndexW-1:0] cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_data,
    input  wire q_head_t              head,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OutDataW-1:0]       m_tdata
);

    logic [8:0]  half_period_reg;
    logic [15:0] stretch_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [8:0]  delay_count_reg, delay_count_next;
    logic [15:0] stretch_count_reg, stretch_count_next;
    logic        stretching_reg, stretching_next;
    logic        scl_low_reg, scl_low_next;
    logic        sda_low_reg, sda_low_next;
    logic        ack_reg, ack_next;
    logic        timeout_reg, timeout_next;
    logic        ack_choice_reg, ack_choice_next;
    logic [7:0]  rx_reg, rx_next;

    logic                out_valid_reg;
    logic [OutDataW-1:0] out_data_reg;

    logic        step;
    logic        ready;
    logic        done;
    logic        go;
    logic        count;
    logic        finished;
    phase_t      target;
    logic [8:0]  half;
    item_t       it;

    assign it   = head.item;
    assign step = head.valid && (!out_valid_reg || m_tready);
    assign pop  = step;

    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        shift_next         = shift_reg;
        delay_count_next   = delay_count_reg;
        stretch_count_next = stretch_count_reg;
        stretching_next    = stretching_reg;
        scl_low_next       = scl_low_reg;
        sda_low_next       = sda_low_reg;
        ack_next           = ack_reg;
        timeout_next       = timeout_reg;
        ack_choice_next    = ack_choice_reg;
        rx_next            = rx_reg;
        ready              = (phase_reg == PH_IDLE);
        done               = 1'b0;
        go                 = 1'b0;
        count              = 1'b1;
        finished           = 1'b0;
        target             = PH_IDLE;
        half               = (half_period_reg == '0) ? 9'd1 : half_period_reg;

        if (ready)
        begin
            if (it.cmd != CMD_NONE)
            begin
                timeout_next    = 1'b0;
                bit_count_next  = '0;
                ack_choice_next = it.send_ack;
                shift_next      = (it.cmd == CMD_WRITE) ? it.tx_byte : 8'd0;
                go              = 1'b1;
                case (it.cmd)
                    CMD_START: target = PH_S0;
                    CMD_STOP:  target = PH_P0;
                    CMD_WRITE: target = PH_W0;
                    default:   target = PH_R0;
                endcase
            end
        end
        else
        begin
            // Clock stretch: the slave holds SCL low after we released it.
            if (stretching_reg)
            begin
                if (!it.scl_in && (stretch_count_reg < stretch_limit_reg))
                begin
                    stretch_count_next = stretch_count_reg + 1'b1;
                    count              = 1'b0;
                end
                else
                begin
                    if (!it.scl_in)
                    begin
                        timeout_next = 1'b1;
                    end
                    stretching_next = 1'b0;
                end
            end
            if (count)
            begin
                delay_count_next = delay_count_reg + 1'b1;
                if (delay_count_next >= half)
                begin
                    go = 1'b1;
                    case (phase_reg)
                        PH_S0:  target = PH_S1;
                        PH_S1:  target = PH_S2;
                        PH_P0:  target = PH_P1;
                        PH_P1:  target = PH_P2;
                        PH_W0:  target = PH_W1;
                        PH_W1:  target = PH_W2;
                        PH_W2:
                        begin
                            shift_next     = {shift_reg[6:0], 1'b0};
                            bit_count_next = bit_count_reg + 1'b1;
                            target = (bit_count_next >= BitsPerByte) ? PH_WA0 : PH_W0;
                        end
                        PH_WA0: target = PH_WA1;
                        PH_WA1:
                        begin
                            ack_next = !it.sda_in;
                            target   = PH_WA2;
                        end
                        PH_R0:  target = PH_R1;
                        PH_R1:
                        begin
                            shift_next     = {shift_reg[6:0], it.sda_in};
                            bit_count_next = bit_count_reg + 1'b1;
                            target = (bit_count_next >= BitsPerByte) ? PH_RA0 : PH_R0;
                        end
                        PH_RA0: target = PH_RA1;
                        PH_RA1: target = PH_RA2;
                        PH_RA2:
                        begin
                            rx_next  = shift_reg;
                            go       = 1'b0;
                            finished = 1'b1;
                        end
                        default:
                        begin
                            go       = 1'b0;
                            finished = 1'b1;
                        end
                    endcase
                end
            end
        end

        if (finished)
        begin
            phase_next         = PH_IDLE;
            stretching_next    = 1'b0;
            delay_count_next   = '0;
            stretch_count_next = '0;
            done               = 1'b1;
        end

        // Segment entry: set the line drives for the new segment.
        if (go)
        begin
            phase_next         = target;
            delay_count_next   = '0;
            stretch_count_next = '0;
            stretching_next    = target inside {PH_S0, PH_P1, PH_W1, PH_WA1, PH_R1, PH_RA1};
            case (target)
                PH_S0:
                begin
                    sda_low_next = 1'b0;
                    scl_low_next = 1'b0;
                end
                PH_S1:  sda_low_next = 1'b1;
                PH_S2:  scl_low_next = 1'b1;
                PH_P0:  sda_low_next = 1'b1;
                PH_P1:  scl_low_next = 1'b0;
                PH_P2:  sda_low_next = 1'b0;
                PH_W0:  sda_low_next = !shift_next[7];
                PH_W1:  scl_low_next = 1'b0;
                PH_W2:  scl_low_next = 1'b1;
                PH_WA0: sda_low_next = 1'b0;
                PH_WA1: scl_low_next = 1'b0;
                PH_WA2: scl_low_next = 1'b1;
                PH_R0:
                begin
                    if (bit_count_next == '0)
                    begin
                        sda_low_next = 1'b0;
                    end
                    else
                    begin
                        scl_low_next = 1'b1;
                    end
                end
                PH_R1:  scl_low_next = 1'b0;
                PH_RA0:
                begin
                    scl_low_next = 1'b1;
                    sda_low_next = ack_choice_next;
                end
                PH_RA1: scl_low_next = 1'b0;
                PH_RA2:
                begin
                    scl_low_next = 1'b1;
                    sda_low_next = 1'b0;
                end
                default:
                begin
                    phase_next      = PH_IDLE;
                    stretching_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg   <= HalfPeriodReset;
            stretch_limit_reg <= StretchLimitReset;
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= '0;
            shift_reg         <= '0;
            delay_count_reg   <= '0;
            stretch_count_reg <= '0;
            stretching_reg    <= 1'b0;
            scl_low_reg       <= 1'b0;
            sda_low_reg       <= 1'b0;
            ack_reg           <= 1'b0;
            timeout_reg       <= 1'b0;
            ack_choice_reg    <= 1'b0;
            rx_reg            <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HALF_PERIOD:   half_period_reg   <= cfg_data[8:0];
                    CFG_STRETCH_LIMIT: stretch_limit_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (step)
            begin
                phase_reg         <= phase_next;
                bit_count_reg     <= bit_count_next;
                shift_reg         <= shift_next;
                delay_count_reg   <= delay_count_next;
                stretch_count_reg <= stretch_count_next;
                stretching_reg    <= stretching_next;
                scl_low_reg       <= scl_low_next;
                sda_low_reg       <= sda_low_next;
                ack_reg           <= ack_next;
                timeout_reg       <= timeout_next;
                ack_choice_reg    <= ack_choice_next;
                rx_reg            <= rx_next;
                out_valid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= {2'b00, timeout_next, ack_next, rx_next, done, ready,
                             sda_low_next, scl_low_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule : i2cm_back
`default_nettype wire
